@@ rtl/vkcg_pkg.sv @@
// Shared constants, types and saturation helpers for the velocity Kalman chi-square gate.
package vkcg_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W        = 32;
   localparam int ACC_W         = 67;
   localparam int SQ_IN_W       = 64;

   localparam logic [15:0] PROC_NOISE_RST = 16'd328;
   localparam logic [15:0] MEAS_NOISE_RST = 16'd1966;
   localparam logic [15:0] GATE_SIGMA_RST = 16'd2560;

   localparam logic [1:0] CSR_PROC_NOISE = 2'd0;
   localparam logic [1:0] CSR_MEAS_NOISE = 2'd1;
   localparam logic [1:0] CSR_GATE_SIGMA = 2'd2;

   typedef enum logic [1:0] {
      KIND_PREDICT  = 2'd0,
      KIND_MEASURE  = 2'd1,
      KIND_SET_VEL  = 2'd2,
      KIND_SET_TIME = 2'd3
   } kind_type;

   function automatic logic signed [ACC_W-1:0] ext32(input logic signed [DATA_W-1:0] v);
      return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = {{(ACC_W-DATA_W){1'b0}}, 32'h7FFF_FFFF};
      lo = {{(ACC_W-DATA_W){1'b1}}, 32'h8000_0000};
      if (v > hi) return 32'sh7FFF_FFFF;
      if (v < lo) return 32'sh8000_0000;
      return $signed(v[DATA_W-1:0]);
   endfunction

endpackage

@@ rtl/velocity_kalman_chi_gate.sv @@
// Top level: 2-D velocity Kalman filter with chi-square gating, sequenced over one multiplier.
//
//   channel  direction  handshake            beat
//   req_     in         req_valid/req_stall  kind, velocity, acceleration, time stamp
//   rsp_     out        rsp_valid/rsp_stall  speed, flags, chi-square, estimate
//   csr_     in         csr_write            index + 16-bit data, no read-back
//
// One beat at a time. An accepted measure runs four serial divisions plus 30
// multiply-accumulate steps on the single 33x33 multiplier, then a square root.
// req_stall is high from acceptance until the result is posted.
// Reset is synchronous, zeroes the velocity and sets the covariance to identity; rsp_stall holds the result register.
module velocity_kalman_chi_gate import vkcg_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_kind,
   input  logic signed [DATA_W-1:0] req_vel_x,
   input  logic signed [DATA_W-1:0] req_vel_y,
   input  logic signed [DATA_W-1:0] req_accel_x,
   input  logic signed [DATA_W-1:0] req_accel_y,
   input  logic [DATA_W-1:0]        req_time_stamp,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [DATA_W-1:0]        rsp_speed,
   output logic                     rsp_accepted,
   output logic [DATA_W-1:0]        rsp_chi_square,
   output logic signed [DATA_W-1:0] rsp_est_vx,
   output logic signed [DATA_W-1:0] rsp_est_vy,
   output logic                     rsp_initialized,
   input  logic                     csr_write,
   input  logic [1:0]               csr_index,
   input  logic [15:0]              csr_wdata
);

   localparam int DEN_W  = 64 - FRAC_BITS;
   localparam int PROD_W = 2 * (DATA_W + 1);
   localparam int UP     = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int DN     = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam logic signed [ACC_W-1:0] RND = (ACC_W'(1) << FRAC_BITS) - 1'b1;
   localparam logic signed [DATA_W-1:0] ONE = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [DATA_W:0] SYM_HI = 33'sh0_7FFF_FFFF;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_SETUP    = 8'b0000_0010,
      ST_MUL      = 8'b0000_0100,
      ST_ACC      = 8'b0000_1000,
      ST_DIV_GO   = 8'b0001_0000,
      ST_DIV_WAIT = 8'b0010_0000,
      ST_SQRT     = 8'b0100_0000,
      ST_DONE     = 8'b1000_0000
   } state_type;

   typedef enum logic [4:0] {
      OP_DET0, OP_DET1, OP_T0A, OP_T0B, OP_T1A, OP_T1B, OP_CA, OP_CB,
      OP_K00A, OP_K00B, OP_K01A, OP_K01B, OP_K10A, OP_K10B, OP_K11A, OP_K11B,
      OP_VXA, OP_VXB, OP_VYA, OP_VYB, OP_P0A, OP_P0B, OP_P1A, OP_P1B,
      OP_P2A, OP_P2B, OP_P3A, OP_P3B, OP_SPA, OP_SPB, OP_PRX, OP_PRY
   } op_type;

   typedef struct packed {
      logic signed [DATA_W:0]  a;
      logic signed [DATA_W:0]  b;
      logic                    raw;
      logic                    sub;
      logic                    first;
      logic                    last;
      logic signed [ACC_W-1:0] base;
   } mop_type;

   function automatic logic signed [DATA_W:0] sx(input logic signed [DATA_W-1:0] v);
      return {v[DATA_W-1], v};
   endfunction

   function automatic logic signed [DATA_W-1:0] clamp_sym(input logic signed [DATA_W:0] v);
      if (v > SYM_HI) return 32'sh7FFF_FFFF;
      if (v < -SYM_HI) return -32'sh7FFF_FFFF;
      return $signed(v[DATA_W-1:0]);
   endfunction

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [1:0] dsel_ff, dsel_in;
   logic [15:0] qn_ff, qn_in, rn_ff, rn_in, gs_ff, gs_in;

   logic [1:0]               kind_ff, kind_in;
   logic signed [DATA_W-1:0] zx_ff, zx_in, zy_ff, zy_in, ax_ff, ax_in, ay_ff, ay_in;
   logic [DATA_W-1:0]        ts_ff, ts_in;

   logic signed [DATA_W-1:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [DATA_W-1:0] p_ff [4];
   logic signed [DATA_W-1:0] p_in [4];
   logic [DATA_W-1:0]        prevt_ff, prevt_in, speed_ff, speed_in, chi_ff, chi_in;
   logic                     init_ff, init_in, accepted_ff, accepted_in;

   logic [DATA_W-1:0]        dt_ff, dt_in;
   logic signed [DATA_W-1:0] d_ff [2];
   logic signed [DATA_W-1:0] d_in [2];
   logic signed [DATA_W-1:0] t_ff [2];
   logic signed [DATA_W-1:0] t_in [2];
   logic signed [DATA_W-1:0] s_ff [4];
   logic signed [DATA_W-1:0] s_in [4];
   logic signed [DATA_W-1:0] i_ff [4];
   logic signed [DATA_W-1:0] i_in [4];
   logic signed [DATA_W-1:0] k_ff [4];
   logic signed [DATA_W-1:0] k_in [4];
   logic signed [DEN_W-1:0]  detq_ff, detq_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]        o_speed_ff, o_speed_in, o_chi_ff, o_chi_in;
   logic signed [DATA_W-1:0] o_vx_ff, o_vx_in, o_vy_ff, o_vy_in;
   logic                     o_acc_ff, o_acc_in, o_init_ff, o_init_in;

   mop_type                  mop;
   logic signed [PROD_W-1:0] prod_sh;
   logic signed [ACC_W-1:0]  term, acc_base, acc_sum, det_adj, det_sh;
   logic signed [DATA_W-1:0] res32;
   logic [ACC_W-1:0]         chi_pos;
   logic [DATA_W-1:0]        rn_q, qn_q, gsq;
   logic [47:0]              sig2;

   logic                     div_start, div_done, sq_start, sq_done;
   logic signed [DATA_W:0]   div_numer;
   logic signed [DATA_W-1:0] div_quot;
   logic [SQ_IN_W/2-1:0]     sq_root;

   vkcg_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (detq_ff),
      .quot  (div_quot),
      .done  (div_done)
   );

   vkcg_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (acc_sum[SQ_IN_W-1:0]),
      .root     (sq_root),
      .done     (sq_done)
   );

   // micro-op operand selection
   always_comb begin
      mop.a     = sx(i_ff[0]);
      mop.b     = sx(d_ff[0]);
      mop.raw   = 1'b0;
      mop.sub   = 1'b0;
      mop.first = 1'b0;
      mop.last  = 1'b0;
      mop.base  = '0;
      case (op_ff)
         OP_DET0: begin
            mop.a = sx(s_ff[0]); mop.b = sx(s_ff[3]); mop.raw = 1'b1; mop.first = 1'b1;
         end
         OP_DET1: begin
            mop.a = sx(s_ff[1]); mop.b = sx(s_ff[2]); mop.raw = 1'b1;
            mop.sub = 1'b1; mop.last = 1'b1;
         end
         OP_T0A: begin mop.a = sx(i_ff[0]); mop.b = sx(d_ff[0]); mop.first = 1'b1; end
         OP_T0B: begin mop.a = sx(i_ff[1]); mop.b = sx(d_ff[1]); mop.last = 1'b1; end
         OP_T1A: begin mop.a = sx(i_ff[2]); mop.b = sx(d_ff[0]); mop.first = 1'b1; end
         OP_T1B: begin mop.a = sx(i_ff[3]); mop.b = sx(d_ff[1]); mop.last = 1'b1; end
         OP_CA:  begin mop.a = sx(d_ff[0]); mop.b = sx(t_ff[0]); mop.first = 1'b1; end
         OP_CB:  begin mop.a = sx(d_ff[1]); mop.b = sx(t_ff[1]); mop.last = 1'b1; end
         OP_K00A: begin mop.a = sx(p_ff[0]); mop.b = sx(i_ff[0]); mop.first = 1'b1; end
         OP_K00B: begin mop.a = sx(p_ff[1]); mop.b = sx(i_ff[2]); mop.last = 1'b1; end
         OP_K01A: begin mop.a = sx(p_ff[0]); mop.b = sx(i_ff[1]); mop.first = 1'b1; end
         OP_K01B: begin mop.a = sx(p_ff[1]); mop.b = sx(i_ff[3]); mop.last = 1'b1; end
         OP_K10A: begin mop.a = sx(p_ff[2]); mop.b = sx(i_ff[0]); mop.first = 1'b1; end
         OP_K10B: begin mop.a = sx(p_ff[3]); mop.b = sx(i_ff[2]); mop.last = 1'b1; end
         OP_K11A: begin mop.a = sx(p_ff[2]); mop.b = sx(i_ff[1]); mop.first = 1'b1; end
         OP_K11B: begin mop.a = sx(p_ff[3]); mop.b = sx(i_ff[3]); mop.last = 1'b1; end
         OP_VXA: begin
            mop.a = sx(k_ff[0]); mop.b = sx(d_ff[0]); mop.first = 1'b1; mop.base = ext32(vx_ff);
         end
         OP_VXB: begin mop.a = sx(k_ff[1]); mop.b = sx(d_ff[1]); mop.last = 1'b1; end
         OP_VYA: begin
            mop.a = sx(k_ff[2]); mop.b = sx(d_ff[0]); mop.first = 1'b1; mop.base = ext32(vy_ff);
         end
         OP_VYB: begin mop.a = sx(k_ff[3]); mop.b = sx(d_ff[1]); mop.last = 1'b1; end
         OP_P0A: begin
            mop.a = sx(k_ff[0]); mop.b = sx(p_ff[0]); mop.sub = 1'b1; mop.first = 1'b1;
            mop.base = ext32(p_ff[0]);
         end
         OP_P0B: begin
            mop.a = sx(k_ff[1]); mop.b = sx(p_ff[2]); mop.sub = 1'b1; mop.last = 1'b1;
         end
         OP_P1A: begin
            mop.a = sx(k_ff[0]); mop.b = sx(p_ff[1]); mop.sub = 1'b1; mop.first = 1'b1;
            mop.base = ext32(p_ff[1]);
         end
         OP_P1B: begin
            mop.a = sx(k_ff[1]); mop.b = sx(p_ff[3]); mop.sub = 1'b1; mop.last = 1'b1;
         end
         OP_P2A: begin
            mop.a = sx(k_ff[2]); mop.b = sx(p_ff[0]); mop.sub = 1'b1; mop.first = 1'b1;
            mop.base = ext32(p_ff[2]);
         end
         OP_P2B: begin
            mop.a = sx(k_ff[3]); mop.b = sx(p_ff[2]); mop.sub = 1'b1; mop.last = 1'b1;
         end
         OP_P3A: begin
            mop.a = sx(k_ff[2]); mop.b = sx(p_ff[1]); mop.sub = 1'b1; mop.first = 1'b1;
            mop.base = ext32(p_ff[3]);
         end
         OP_P3B: begin
            mop.a = sx(k_ff[3]); mop.b = sx(p_ff[3]); mop.sub = 1'b1; mop.last = 1'b1;
         end
         OP_SPA: begin
            mop.a = sx(vx_ff); mop.b = sx(vx_ff); mop.raw = 1'b1; mop.first = 1'b1;
         end
         OP_SPB: begin
            mop.a = sx(vy_ff); mop.b = sx(vy_ff); mop.raw = 1'b1; mop.last = 1'b1;
         end
         OP_PRX: begin
            mop.a = sx(ax_ff); mop.b = $signed({1'b0, dt_ff}); mop.first = 1'b1;
            mop.last = 1'b1; mop.base = ext32(vx_ff);
         end
         OP_PRY: begin
            mop.a = sx(ay_ff); mop.b = $signed({1'b0, dt_ff}); mop.first = 1'b1;
            mop.last = 1'b1; mop.base = ext32(vy_ff);
         end
         default: ;
      endcase
   end

   always_comb begin
      prod_sh  = prod_ff >>> FRAC_BITS;
      term     = mop.raw ? {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff}
                         : {{(ACC_W-PROD_W){prod_sh[PROD_W-1]}}, prod_sh};
      acc_base = mop.first ? mop.base : acc_ff;
      acc_sum  = mop.sub ? acc_base - term : acc_base + term;
      res32    = sat32(acc_sum);
      det_adj  = acc_sum[ACC_W-1] ? acc_sum + RND : acc_sum;
      det_sh   = det_adj >>> FRAC_BITS;
      chi_pos  = acc_sum[ACC_W-1] ? '0 : acc_sum;
      rn_q     = (32'(rn_ff) << UP) >> DN;
      qn_q     = (32'(qn_ff) << UP) >> DN;
      gsq      = 32'(gs_ff) * 32'(gs_ff);
      sig2     = (48'(gsq) << UP) >> DN;
      case (dsel_ff)
         2'd0:    div_numer = sx(s_ff[3]);
         2'd1:    div_numer = -sx(s_ff[1]);
         2'd2:    div_numer = -sx(s_ff[2]);
         default: div_numer = sx(s_ff[0]);
      endcase
      div_start = (state_ff == ST_DIV_GO);
      sq_start  = (state_ff == ST_ACC) && (op_ff == OP_SPB);
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      dsel_in     = dsel_ff;
      qn_in       = qn_ff;
      rn_in       = rn_ff;
      gs_in       = gs_ff;
      kind_in     = kind_ff;
      zx_in       = zx_ff;
      zy_in       = zy_ff;
      ax_in       = ax_ff;
      ay_in       = ay_ff;
      ts_in       = ts_ff;
      vx_in       = vx_ff;
      vy_in       = vy_ff;
      p_in        = p_ff;
      prevt_in    = prevt_ff;
      speed_in    = speed_ff;
      chi_in      = chi_ff;
      init_in     = init_ff;
      accepted_in = accepted_ff;
      dt_in       = dt_ff;
      d_in        = d_ff;
      t_in        = t_ff;
      s_in        = s_ff;
      i_in        = i_ff;
      k_in        = k_ff;
      detq_in     = detq_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      o_speed_in  = o_speed_ff;
      o_chi_in    = o_chi_ff;
      o_vx_in     = o_vx_ff;
      o_vy_in     = o_vy_ff;
      o_acc_in    = o_acc_ff;
      o_init_in   = o_init_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_write) begin
         case (csr_index)
            CSR_PROC_NOISE: qn_in = csr_wdata;
            CSR_MEAS_NOISE: rn_in = csr_wdata;
            CSR_GATE_SIGMA: gs_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               zx_in    = req_vel_x;
               zy_in    = req_vel_y;
               ax_in    = req_accel_x;
               ay_in    = req_accel_y;
               ts_in    = req_time_stamp;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            accepted_in = 1'b0;
            state_in    = ST_DONE;
            case (kind_ff)
               KIND_PREDICT: begin
                  if (init_ff) begin
                     dt_in    = ts_ff - prevt_ff;
                     prevt_in = ts_ff;
                     p_in[0]  = sat32(ext32(p_ff[0]) + ext32($signed(qn_q)));
                     p_in[3]  = sat32(ext32(p_ff[3]) + ext32($signed(qn_q)));
                     op_in    = OP_PRX;
                     state_in = ST_MUL;
                  end
               end
               KIND_MEASURE: begin
                  if (init_ff) begin
                     d_in[0]  = sat32(ext32(zx_ff) - ext32(vx_ff));
                     d_in[1]  = sat32(ext32(zy_ff) - ext32(vy_ff));
                     s_in[0]  = clamp_sym(sx(p_ff[0]) + sx($signed(rn_q)));
                     s_in[1]  = clamp_sym(sx(p_ff[1]));
                     s_in[2]  = clamp_sym(sx(p_ff[2]));
                     s_in[3]  = clamp_sym(sx(p_ff[3]) + sx($signed(rn_q)));
                     op_in    = OP_DET0;
                     state_in = ST_MUL;
                  end
               end
               KIND_SET_VEL: begin
                  init_in  = 1'b1;
                  vx_in    = zx_ff;
                  vy_in    = zy_ff;
                  p_in[0]  = '0;
                  p_in[1]  = '0;
                  p_in[2]  = '0;
                  p_in[3]  = '0;
                  op_in    = OP_SPA;
                  state_in = ST_MUL;
               end
               default: prevt_in = ts_ff;
            endcase
         end
         ST_MUL: begin
            prod_in  = mop.a * mop.b;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in   = acc_sum;
            op_in    = op_type'(op_ff + 1'b1);
            state_in = ST_MUL;
            case (op_ff)
               OP_DET1: begin
                  detq_in = det_sh[DEN_W-1:0];
                  dsel_in = 2'd0;
                  state_in = (det_sh == '0) ? ST_DONE : ST_DIV_GO;
               end
               OP_T0B: t_in[0] = res32;
               OP_T1B: t_in[1] = res32;
               OP_CB: begin
                  chi_in = (chi_pos > ACC_W'(33'h0_FFFF_FFFF)) ? 32'hFFFF_FFFF
                                                               : chi_pos[DATA_W-1:0];
                  if (chi_pos > ACC_W'(sig2)) begin
                     state_in = ST_DONE;
                  end else begin
                     accepted_in = 1'b1;
                  end
               end
               OP_K00B: k_in[0] = res32;
               OP_K01B: k_in[1] = res32;
               OP_K10B: k_in[2] = res32;
               OP_K11B: k_in[3] = res32;
               OP_VXB, OP_PRX: vx_in = res32;
               OP_VYB: vy_in = res32;
               OP_PRY: begin
                  vy_in = res32;
                  op_in = OP_SPA;
               end
               OP_P0B: s_in[0] = res32;
               OP_P1B: s_in[1] = res32;
               OP_P2B: s_in[2] = res32;
               OP_P3B: begin
                  p_in[0] = s_ff[0];
                  p_in[1] = s_ff[1];
                  p_in[2] = s_ff[2];
                  p_in[3] = res32;
               end
               OP_SPB: state_in = ST_SQRT;
               default: ;
            endcase
         end
         ST_DIV_GO: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               i_in[dsel_ff] = div_quot;
               if (dsel_ff == 2'd3) begin
                  op_in    = OP_T0A;
                  state_in = ST_MUL;
               end else begin
                  dsel_in  = dsel_ff + 1'b1;
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_SQRT: begin
            if (sq_done) begin
               speed_in = sq_root;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               o_speed_in   = speed_ff;
               o_chi_in     = chi_ff;
               o_vx_in      = vx_ff;
               o_vy_in      = vy_ff;
               o_acc_in     = accepted_ff;
               o_init_in    = init_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_DET0;
         dsel_ff      <= '0;
         qn_ff        <= PROC_NOISE_RST;
         rn_ff        <= MEAS_NOISE_RST;
         gs_ff        <= GATE_SIGMA_RST;
         vx_ff        <= '0;
         vy_ff        <= '0;
         p_ff[0]      <= ONE;
         p_ff[1]      <= '0;
         p_ff[2]      <= '0;
         p_ff[3]      <= ONE;
         prevt_ff     <= '0;
         speed_ff     <= '0;
         chi_ff       <= '0;
         init_ff      <= 1'b0;
         accepted_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         dsel_ff      <= dsel_in;
         qn_ff        <= qn_in;
         rn_ff        <= rn_in;
         gs_ff        <= gs_in;
         vx_ff        <= vx_in;
         vy_ff        <= vy_in;
         p_ff         <= p_in;
         prevt_ff     <= prevt_in;
         speed_ff     <= speed_in;
         chi_ff       <= chi_in;
         init_ff      <= init_in;
         accepted_ff  <= accepted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff    <= kind_in;
      zx_ff      <= zx_in;
      zy_ff      <= zy_in;
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      ts_ff      <= ts_in;
      dt_ff      <= dt_in;
      d_ff       <= d_in;
      t_ff       <= t_in;
      s_ff       <= s_in;
      i_ff       <= i_in;
      k_ff       <= k_in;
      detq_ff    <= detq_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      o_speed_ff <= o_speed_in;
      o_chi_ff   <= o_chi_in;
      o_vx_ff    <= o_vx_in;
      o_vy_ff    <= o_vy_in;
      o_acc_ff   <= o_acc_in;
      o_init_ff  <= o_init_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_speed       = o_speed_ff;
   assign rsp_accepted    = o_acc_ff;
   assign rsp_chi_square  = o_chi_ff;
   assign rsp_est_vx      = o_vx_ff;
   assign rsp_est_vy      = o_vy_ff;
   assign rsp_initialized = o_init_ff;

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished outside its wait state");

   a_sqrt_done_in_sqrt: assert property (@(posedge clock) disable iff (reset)
      sq_done |-> state_ff == ST_SQRT)
      else $error("square root finished outside its wait state");

   a_accept_needs_init: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |-> rsp_initialized)
      else $error("gated update reported on an uninitialized filter");

   a_post_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result posted outside the done state");

endmodule

@@ rtl/vkcg_div.sv @@
// Iterative restoring divider: saturated (s * 2^FRAC_BITS) / den, truncated toward zero.
module vkcg_div import vkcg_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [DATA_W:0]        numer,
   input  logic signed [63-FRAC_BITS:0]  denom,
   output logic signed [DATA_W-1:0]      quot,
   output logic                          done
);

   localparam int DEN_W = 64 - FRAC_BITS;
   localparam int NUM_W = DATA_W + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic [DEN_W-1:0]        rem_ff, rem_in;
   logic                    neg_ff, neg_in;
   logic signed [DATA_W-1:0] quot_ff, quot_in;

   logic [DATA_W:0]  nabs;
   logic [DEN_W-1:0] dabs;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   diff;
   logic             ge;

   always_comb begin
      nabs    = numer[DATA_W] ? (DATA_W+1)'(-numer) : numer;
      dabs    = denom[DEN_W-1] ? DEN_W'(-denom) : denom;
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      diff    = rem_sh - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         num_in  = {nabs[DATA_W-1:0], {FRAC_BITS{1'b0}}};
         den_in  = dabs;
         rem_in  = '0;
         neg_in  = numer[DATA_W] ^ denom[DEN_W-1];
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            num_in = {num_ff[NUM_W-2:0], ge};
            rem_in = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            cnt_in = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               if (num_ff > {{(NUM_W-DATA_W){1'b0}}, 32'h8000_0000}) begin
                  quot_in = 32'sh8000_0000;
               end else begin
                  quot_in = $signed(-num_ff[DATA_W-1:0]);
               end
            end else begin
               if (num_ff > {{(NUM_W-DATA_W){1'b0}}, 32'h7FFF_FFFF}) begin
                  quot_in = 32'sh7FFF_FFFF;
               end else begin
                  quot_in = $signed(num_ff[DATA_W-1:0]);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;
   assign done = done_ff;

endmodule

@@ rtl/vkcg_sqrt.sv @@
// Iterative floor integer square root, one root bit per cycle.
module vkcg_sqrt import vkcg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [SQ_IN_W-1:0]     radicand,
   output logic [SQ_IN_W/2-1:0]   root,
   output logic                   done
);

   localparam int ROOT_W = SQ_IN_W / 2;
   localparam int CNT_W  = $clog2(ROOT_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SQ_IN_W-1:0]  val_ff, val_in;
   logic [ROOT_W+1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;

   logic [ROOT_W+1:0]   rem_sh;
   logic [ROOT_W+1:0]   trial;

   always_comb begin
      rem_sh  = {rem_ff[ROOT_W-1:0], val_ff[SQ_IN_W-1:SQ_IN_W-2]};
      trial   = {root_ff, 2'b01};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ROOT_W);
         val_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            val_in = {val_ff[SQ_IN_W-3:0], 2'b00};
            cnt_in = cnt_ff - 1'b1;
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule
